// ----- src/sfa_pkg.sv -----
package sfa_pkg;

   localparam int RES_BITS = 63;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CHK,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

endpackage

// ----- src/sfa_div.sv -----
module sfa_div #(
   parameter int W = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(W - 1);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (diff[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without run");
   a_no_start_while_run: assert property (@(posedge clock) disable iff (reset)
      run_ff && !done_ff |-> !start || cnt_ff == CW'(W - 1))
      else $error("divider restarted mid-run");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule

// ----- src/signed_fraction_alu.sv -----
// Signed fraction ALU: exact add, subtract, multiply, divide of
// sign-magnitude fractions, result reduced by its GCD.
// Input: drive req_* with start high; the word is taken on the edge where
// start is high and busy is low. busy then stays high until the result
// has been shown.
// Output: rsp_strobe is high for exactly one cycle with rsp_res_num,
// rsp_res_den and rsp_res_neg valid; the receiver must take it then.
// Steps: shift-add multiplies of the cross products in turn (one shared
// adder), sum and check, binary GCD steps (one subtract or shift per
// cycle), then two restoring divisions and the output state.
// A result whose numerator equals its denominator or is zero, or whose
// denominator is zero, skips the GCD and divisions. One word in flight
// at a time; busy drops the cycle after the strobe.
// Reset: synchronous, returns to idle, drops busy and rsp_strobe.
module signed_fraction_alu #(
   parameter int MAG_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_op,
   input  logic [MAG_BITS-1:0]          req_a_num,
   input  logic [MAG_BITS-1:0]          req_a_den,
   input  logic                         req_a_neg,
   input  logic [MAG_BITS-1:0]          req_b_num,
   input  logic [MAG_BITS-1:0]          req_b_den,
   input  logic                         req_b_neg,
   output logic                         rsp_strobe,
   output logic [sfa_pkg::RES_BITS-1:0] rsp_res_num,
   output logic [sfa_pkg::RES_BITS-1:0] rsp_res_den,
   output logic                         rsp_res_neg
);

   localparam int PW = 2 * MAG_BITS;
   localparam int SW = PW + 1;
   localparam int CW = $clog2(MAG_BITS);

   sfa_pkg::state_type state_ff, state_in;
   sfa_pkg::op_type    op_ff, op_in;

   logic [MAG_BITS-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [MAG_BITS-1:0] an_in, ad_in, bn_in, bd_in;
   logic                aneg_ff, bneg_ff, aneg_in, bneg_in;
   logic [1:0]          k_ff, k_in;
   logic [CW-1:0]       bit_ff, bit_in;
   logic [PW-1:0]       mcand_ff, mcand_in, acc_ff, acc_in, acc_sum;
   logic [MAG_BITS-1:0] mplier_ff, mplier_in;
   logic [PW-1:0]       p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in;
   logic [SW-1:0]       num_ff, den_ff, u_ff, v_ff;
   logic [SW-1:0]       num_in, den_in, u_in, v_in;
   logic                neg_ff, neg_in;
   logic                div_start, div_done;
   logic [SW-1:0]       div_dividend, div_q;
   logic [SW-1:0]       sa, sb, pos_t, neg_t;
   logic                beff;
   logic                mul_last, gcd_eq;

   function automatic logic [MAG_BITS-1:0] pick_mcand(
      input logic [1:0] k, input logic [MAG_BITS-1:0] an, input logic [MAG_BITS-1:0] bn,
      input logic [MAG_BITS-1:0] ad);
      case (k)
         2'd0:    pick_mcand = an;
         2'd1:    pick_mcand = bn;
         default: pick_mcand = ad;
      endcase
   endfunction

   assign acc_sum  = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign mul_last = (bit_ff == CW'(MAG_BITS - 1));
   assign gcd_eq   = (u_ff == v_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfa_pkg::ST_IDLE: if (start) state_in = sfa_pkg::ST_MUL;
         sfa_pkg::ST_MUL:  if (mul_last && k_ff == 2'd2) state_in = sfa_pkg::ST_SUM;
         sfa_pkg::ST_SUM:  state_in = sfa_pkg::ST_CHK;
         sfa_pkg::ST_CHK: begin
            if (num_ff == den_ff || num_ff == '0 || den_ff == '0)
               state_in = sfa_pkg::ST_DONE;
            else
               state_in = sfa_pkg::ST_GCD;
         end
         sfa_pkg::ST_GCD:  if (gcd_eq) state_in = sfa_pkg::ST_DIVN;
         sfa_pkg::ST_DIVN: if (div_done) state_in = sfa_pkg::ST_DIVD;
         sfa_pkg::ST_DIVD: if (div_done) state_in = sfa_pkg::ST_DONE;
         sfa_pkg::ST_DONE: state_in = sfa_pkg::ST_IDLE;
         default:          state_in = sfa_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      op_in = op_ff;  an_in = an_ff;  ad_in = ad_ff;  bn_in = bn_ff;  bd_in = bd_ff;
      aneg_in = aneg_ff;  bneg_in = bneg_ff;
      k_in = k_ff;  bit_in = bit_ff;  mcand_in = mcand_ff;  mplier_in = mplier_ff;
      acc_in = acc_ff;  p0_in = p0_ff;  p1_in = p1_ff;  p2_in = p2_ff;
      num_in = num_ff;  den_in = den_ff;  u_in = u_ff;  v_in = v_ff;  neg_in = neg_ff;
      div_start = 1'b0;
      div_dividend = num_ff;
      beff  = bneg_ff ^ (op_ff == sfa_pkg::OP_SUB);
      sa    = SW'(p0_ff);
      sb    = SW'(p1_ff);
      pos_t = aneg_ff ? sb : sa;
      neg_t = aneg_ff ? sa : sb;
      case (state_ff)
         sfa_pkg::ST_IDLE: begin
            if (start) begin
               op_in = sfa_pkg::op_type'(req_op);
               an_in = req_a_num;  ad_in = req_a_den;  aneg_in = req_a_neg;
               bn_in = req_b_num;  bd_in = req_b_den;  bneg_in = req_b_neg;
               k_in = 2'd0;
               bit_in = '0;
               acc_in = '0;
               mcand_in = PW'(req_a_num);
               mplier_in = (req_op == sfa_pkg::OP_MUL) ? req_b_num : req_b_den;
            end
         end
         sfa_pkg::ST_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[PW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MAG_BITS-1:1]};
            bit_in    = bit_ff + 1'b1;
            if (mul_last) begin
               case (k_ff)
                  2'd0:    p0_in = acc_sum;
                  2'd1:    p1_in = acc_sum;
                  default: p2_in = acc_sum;
               endcase
               k_in   = k_ff + 1'b1;
               bit_in = '0;
               acc_in = '0;
               mcand_in  = PW'(pick_mcand(k_ff + 1'b1, an_ff, bn_ff, ad_ff));
               mplier_in = (k_ff == 2'd0) ? ad_ff :
                           ((op_ff == sfa_pkg::OP_DIV) ? bn_ff : bd_ff);
            end
         end
         sfa_pkg::ST_SUM: begin
            den_in = SW'(p2_ff);
            if (op_ff == sfa_pkg::OP_MUL || op_ff == sfa_pkg::OP_DIV) begin
               num_in = sa;
               neg_in = aneg_ff ^ bneg_ff;
            end else if (aneg_ff == beff) begin
               num_in = sa + sb;
               neg_in = aneg_ff;
            end else if (pos_t >= neg_t) begin
               num_in = pos_t - neg_t;
               neg_in = 1'b0;
            end else begin
               num_in = neg_t - pos_t;
               neg_in = 1'b1;
            end
            u_in = num_in;
            v_in = den_in;
         end
         sfa_pkg::ST_CHK: begin
            if (num_ff == den_ff) begin
               num_in = SW'(1);
               den_in = SW'(1);
            end
         end
         sfa_pkg::ST_GCD: begin
            if (gcd_eq) begin
               div_start = 1'b1;
            end else if (!u_ff[0] && !v_ff[0]) begin
               // common factor of two: strip it from the fraction too
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               num_in = num_ff >> 1;
               den_in = den_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         sfa_pkg::ST_DIVN: begin
            if (div_done) begin
               num_in = div_q;
               div_start = 1'b1;
               div_dividend = den_ff;
            end
         end
         sfa_pkg::ST_DIVD: begin
            if (div_done) den_in = div_q;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;  an_ff <= an_in;  ad_ff <= ad_in;  bn_ff <= bn_in;  bd_ff <= bd_in;
      aneg_ff <= aneg_in;  bneg_ff <= bneg_in;
      k_ff <= k_in;  bit_ff <= bit_in;  mcand_ff <= mcand_in;  mplier_ff <= mplier_in;
      acc_ff <= acc_in;  p0_ff <= p0_in;  p1_ff <= p1_in;  p2_ff <= p2_in;
      num_ff <= num_in;  den_ff <= den_in;  u_ff <= u_in;  v_ff <= v_in;  neg_ff <= neg_in;
   end

   sfa_div #(.W(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (u_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy        = (state_ff != sfa_pkg::ST_IDLE);
   assign rsp_strobe  = (state_ff == sfa_pkg::ST_DONE);
   assign rsp_res_num = sfa_pkg::RES_BITS'(num_ff);
   assign rsp_res_den = sfa_pkg::RES_BITS'(den_ff);
   assign rsp_res_neg = neg_ff;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("word taken but not busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result shown twice");
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfa_pkg::ST_GCD |-> u_ff != '0 && v_ff != '0)
      else $error("gcd operand reached zero");
   a_div_only_reduce: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == sfa_pkg::ST_DIVN || state_ff == sfa_pkg::ST_DIVD)
      else $error("divider finished outside reduction");

endmodule
